/* rtl/qrs_pkg.sv */
// qrs_pkg: shared types and constants for the quadratic root solver
// no dependencies; imported by every module of the block
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DISC_W        = 66;  // discriminant magnitude width
  localparam int ROOT_W        = 33;  // floor square root width
  localparam int SQRT_STEPS    = 33;  // one result bit per stage
  localparam int DIV_STEPS     = 33;  // one quotient bit per stage
  localparam int NUM_W         = 36;  // signed numerator width

  typedef enum logic [1:0] {
    KIND_ONE  = 2'd0,
    KIND_TWO  = 2'd1,
    KIND_CPLX = 2'd2
  } root_kind_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
  } coef_item_t;

  typedef struct packed {
    logic [1:0]         root_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               overflow;
    logic               zero_leading;
  } root_item_t;

  // coefficients and class that travel beside the discriminant and root
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    root_kind_t         kind;
  } side_t;

endpackage

/* rtl/qrs_disc.sv */
// qrs_disc: three-stage discriminant b*b - 4ac as sign class and magnitude
// depends on qrs_pkg
module qrs_disc (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  qrs_pkg::coef_item_t coef,
  output logic                d_valid,
  output logic [qrs_pkg::DISC_W-1:0] disc,
  output qrs_pkg::side_t      side
);
  import qrs_pkg::*;

  // stage 1: magnitudes and signs
  logic        v1;
  logic [31:0] am, bm, cm;
  logic        acs;
  logic signed [31:0] a1, b1;
  // stage 2: products
  logic        v2;
  logic [63:0] b2, pac;
  logic        acn;
  logic signed [31:0] a2, b2s;
  // stage 3: discriminant
  logic        v3;
  logic [DISC_W-1:0] d3, d_next;
  root_kind_t  k3, k_next;
  logic signed [31:0] a3, b3;

  logic [DISC_W-1:0] b2w, f4w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am  <= coef.coef_a[31] ? 32'(-coef.coef_a) : 32'(coef.coef_a);
      bm  <= coef.coef_b[31] ? 32'(-coef.coef_b) : 32'(coef.coef_b);
      cm  <= coef.coef_c[31] ? 32'(-coef.coef_c) : 32'(coef.coef_c);
      acs <= coef.coef_a[31] ^ coef.coef_c[31];
      a1  <= coef.coef_a;
      b1  <= coef.coef_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2  <= bm * bm;
      pac <= am * cm;
      acn <= acs && (am != 32'd0) && (cm != 32'd0);
      a2  <= a1;
      b2s <= b1;
    end
  end

  // sign class and magnitude of the discriminant
  assign b2w = {2'b00, b2};
  assign f4w = {pac, 2'b00};

  always_comb begin
    if (acn) begin
      d_next = b2w + f4w;
      k_next = (d_next == '0) ? KIND_ONE : KIND_TWO;
    end else if (b2w >= f4w) begin
      d_next = b2w - f4w;
      k_next = (b2w == f4w) ? KIND_ONE : KIND_TWO;
    end else begin
      d_next = f4w - b2w;
      k_next = KIND_CPLX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3 <= d_next;
      k3 <= k_next;
      a3 <= a2;
      b3 <= b2s;
    end
  end

  assign d_valid   = v3;
  assign disc      = d3;
  assign side.a    = a3;
  assign side.b    = b3;
  assign side.kind = k3;

endmodule

/* rtl/qrs_sqrt.sv */
// qrs_sqrt: pipelined digit-by-digit floor square root, one root bit per stage
// depends on qrs_pkg
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [qrs_pkg::DISC_W-1:0]  disc,
  input  qrs_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [qrs_pkg::ROOT_W-1:0]  root,
  output qrs_pkg::side_t              out_side
);
  import qrs_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic              vl [SQRT_STEPS];
  logic [ROOT_W-1:0] rt [SQRT_STEPS];
  logic [REM_W-1:0]  rm [SQRT_STEPS];
  logic [DISC_W-1:0] dd [SQRT_STEPS];
  side_t             sd [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic              p_v;
    logic [ROOT_W-1:0] p_rt;
    logic [REM_W-1:0]  p_rm;
    logic [DISC_W-1:0] p_dd;
    side_t             p_sd;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign p_v  = in_valid;
      assign p_rt = '0;
      assign p_rm = '0;
      assign p_dd = disc;
      assign p_sd = in_side;
    end else begin : g_rest
      assign p_v  = vl[k-1];
      assign p_rt = rt[k-1];
      assign p_rm = rm[k-1];
      assign p_dd = dd[k-1];
      assign p_sd = sd[k-1];
    end

    // bring down two bits and try root*4+1
    assign cur   = {p_rm, p_dd[DISC_W-1:DISC_W-2]};
    assign trial = {2'b00, p_rt, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rm[k] <= REM_W'(cur - trial);
          rt[k] <= {p_rt[ROOT_W-2:0], 1'b1};
        end else begin
          rm[k] <= cur[REM_W-1:0];
          rt[k] <= {p_rt[ROOT_W-2:0], 1'b0};
        end
        dd[k] <= {p_dd[DISC_W-3:0], 2'b00};
        sd[k] <= p_sd;
      end
    end
  end

  assign out_valid = vl[SQRT_STEPS-1];
  assign root      = rt[SQRT_STEPS-1];
  assign out_side  = sd[SQRT_STEPS-1];

endmodule

/* rtl/qrs_div.sv */
// qrs_div: numerator set-up, two-lane pipelined restoring divide by 2a, saturation
// depends on qrs_pkg
module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [qrs_pkg::ROOT_W-1:0] root,
  input  qrs_pkg::side_t             in_side,
  output logic                       out_valid,
  output qrs_pkg::root_item_t        result
);
  import qrs_pkg::*;

  localparam int MAG_W = NUM_W - 1;
  localparam int NW    = MAG_W + FRAC_BITS;   // scaled dividend width
  localparam int HI_W  = NW - DIV_STEPS;

  // stage a: signed numerators and divisor magnitude
  logic                           va;
  logic [1:0][NUM_W-1:0]          an;
  logic [32:0]                    adm;
  logic                           asg, azl;
  root_kind_t                     ak;
  logic signed [NUM_W-1:0]        nb, sx;
  logic [1:0][NUM_W-1:0]          an_next;

  // stage b: magnitudes, high part and range check
  logic                           vb;
  logic [1:0][32:0]               brem, bnlo;
  logic [1:0]                     bbig, bneg;
  logic [32:0]                    bdm;
  logic                           bzl;
  root_kind_t                     bk;

  // divide stages
  logic              dv   [DIV_STEPS];
  logic [1:0][32:0]  drem [DIV_STEPS];
  logic [1:0][32:0]  dnlo [DIV_STEPS];
  logic [1:0][32:0]  dq   [DIV_STEPS];
  logic [1:0]        dbig [DIV_STEPS];
  logic [1:0]        dneg [DIV_STEPS];
  logic [32:0]       ddm  [DIV_STEPS];
  logic              dzl  [DIV_STEPS];
  root_kind_t        dk   [DIV_STEPS];

  assign nb = -NUM_W'(in_side.b);
  assign sx = NUM_W'(root);

  // numerators per root class
  always_comb begin
    case (in_side.kind)
      KIND_TWO: begin
        an_next[0] = NUM_W'(nb - sx);
        an_next[1] = NUM_W'(nb + sx);
      end
      KIND_CPLX: begin
        an_next[0] = nb;
        an_next[1] = sx;
      end
      default: begin
        an_next[0] = nb;
        an_next[1] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an  <= an_next;
      adm <= in_side.a[31] ? {33'(-in_side.a)} << 1 : {33'(in_side.a)} << 1;
      asg <= in_side.a[31];
      azl <= (in_side.a == 32'sd0);
      ak  <= in_side.kind;
    end
  end

  // stage b per lane
  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] mag;
    logic [NW-1:0]    nsc;
    logic [32:0]      hi;
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        mag     = an[l][NUM_W-1] ? MAG_W'(-an[l]) : an[l][MAG_W-1:0];
        nsc     = {mag, {FRAC_BITS{1'b0}}};
        hi      = {{(33-HI_W){1'b0}}, nsc[NW-1:DIV_STEPS]};
        brem[l] <= hi;
        bnlo[l] <= nsc[DIV_STEPS-1:0];
        bbig[l] <= (hi >= adm);
        bneg[l] <= (an[l][NUM_W-1] ^ asg) && (an[l] != '0);
      end
      bdm <= adm;
      bzl <= azl;
      bk  <= ak;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic             p_v;
    logic [1:0][32:0] p_rem, p_nlo, p_q;
    logic [1:0]       p_big, p_neg;
    logic [32:0]      p_dm;
    logic             p_zl;
    root_kind_t       p_k;

    if (j == 0) begin : g_first
      assign p_v   = vb;
      assign p_rem = brem;
      assign p_nlo = bnlo;
      assign p_q   = '0;
      assign p_big = bbig;
      assign p_neg = bneg;
      assign p_dm  = bdm;
      assign p_zl  = bzl;
      assign p_k   = bk;
    end else begin : g_rest
      assign p_v   = dv[j-1];
      assign p_rem = drem[j-1];
      assign p_nlo = dnlo[j-1];
      assign p_q   = dq[j-1];
      assign p_big = dbig[j-1];
      assign p_neg = dneg[j-1];
      assign p_dm  = ddm[j-1];
      assign p_zl  = dzl[j-1];
      assign p_k   = dk[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= p_v;
      end
    end

    // one restoring step in each lane
    always_ff @(posedge clk) begin
      logic [33:0] cur;
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          cur = {p_rem[l], p_nlo[l][32]};
          if (cur >= {1'b0, p_dm}) begin
            drem[j][l] <= 33'(cur - {1'b0, p_dm});
            dq[j][l]   <= {p_q[l][31:0], 1'b1};
          end else begin
            drem[j][l] <= cur[32:0];
            dq[j][l]   <= {p_q[l][31:0], 1'b0};
          end
          dnlo[j][l] <= {p_nlo[l][31:0], 1'b0};
        end
        dbig[j] <= p_big;
        dneg[j] <= p_neg;
        ddm[j]  <= p_dm;
        dzl[j]  <= p_zl;
        dk[j]   <= p_k;
      end
    end
  end

  // sign, saturation and zero leading coefficient
  logic [1:0][31:0] val;
  logic [1:0]       ovl;

  always_comb begin
    logic [32:0] q;
    for (int l = 0; l < 2; l++) begin
      q = dq[DIV_STEPS-1][l];
      if (dbig[DIV_STEPS-1][l]) begin
        ovl[l] = 1'b1;
        val[l] = dneg[DIV_STEPS-1][l] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (dneg[DIV_STEPS-1][l]) begin
        ovl[l] = (q > 33'h0_8000_0000);
        val[l] = ovl[l] ? 32'h8000_0000 : 32'(33'd0 - q);
      end else begin
        ovl[l] = (q > 33'h0_7fff_ffff);
        val[l] = ovl[l] ? 32'h7fff_ffff : q[31:0];
      end
    end
  end

  assign out_valid           = dv[DIV_STEPS-1];
  assign result.root_kind    = dk[DIV_STEPS-1];
  assign result.zero_leading = dzl[DIV_STEPS-1];
  assign result.first_value  = dzl[DIV_STEPS-1] ? 32'sd0 : val[0];
  assign result.second_value = dzl[DIV_STEPS-1] ? 32'sd0 : val[1];
  assign result.overflow     = !dzl[DIV_STEPS-1] && (ovl[0] || ovl[1]);

endmodule

/* rtl/quadratic_root_solver.sv */
// Quadratic root solver: one coefficient set (a, b, c, signed fixed point with
// FRAC_BITS fraction bits) in, one result out, one item per clock cycle
// while coef_ready is high. Each item passes 72 register stages: 3 discriminant
// stages, 33 square-root stages (one root bit each), 2 numerator set-up
// stages, 33 divider stages (one quotient bit each) and the output register.
// The output has a one-entry skid buffer, so coef_ready stays high while a
// result waits and drops only once the skid entry is taken; the whole pipeline
// then holds until root_ready returns.
// depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                coef_valid,
  output logic                coef_ready,
  input  qrs_pkg::coef_item_t coef,
  output logic                root_valid,
  input  logic                root_ready,
  output qrs_pkg::root_item_t root
);
  import qrs_pkg::*;

  logic              en;
  logic              d_valid, s_valid, q_valid;
  logic [DISC_W-1:0] disc;
  logic [ROOT_W-1:0] sq;
  side_t             d_side, s_side;
  root_item_t        q_item;

  logic              skid_valid;
  root_item_t        skid;

  // pipeline advances while the skid entry is free
  assign en         = !skid_valid;
  assign coef_ready = en;

  qrs_disc u_disc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (coef_valid),
    .coef     (coef),
    .d_valid  (d_valid),
    .disc     (disc),
    .side     (d_side)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .disc      (disc),
    .in_side   (d_side),
    .out_valid (s_valid),
    .root      (sq),
    .out_side  (s_side)
  );

  qrs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .root      (sq),
    .in_side   (s_side),
    .out_valid (q_valid),
    .result    (q_item)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (root_valid && !root_ready) begin
      if (q_valid && en) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      root_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      root_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (root_valid && !root_ready) begin
      if (q_valid && en) begin
        skid <= q_item;
      end
    end else if (skid_valid) begin
      root <= skid;
    end else if (q_valid) begin
      root <= q_item;
    end
  end

endmodule

/* tb/quadratic_root_solver_tb.sv */
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// predicts each result from the coefficients and checks it against the output
// depends on qrs_pkg and quadratic_root_solver
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int FB          = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 120;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;

  logic       clk;
  logic       rst;
  logic       coef_valid;
  logic       coef_ready;
  coef_item_t coef;
  logic       root_valid;
  logic       root_ready;
  root_item_t root;

  root_item_t pending_roots[$];
  int         mismatches;
  int         cycles;
  int         rx_gap;
  int         rx_hold;
  bit         tx_fast;
  bit         rx_fast;

  quadratic_root_solver dut (
    .clk        (clk),
    .rst        (rst),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef       (coef),
    .root_valid (root_valid),
    .root_ready (root_ready),
    .root       (root)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor of the exact square root of the discriminant magnitude
  function automatic logic [34:0] floor_sqrt(logic [66:0] v);
    logic [69:0] r;
    logic [69:0] t;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      t = r | (70'd1 << i);
      if (t * t <= {3'b0, v}) r = t;
    end
    return r[34:0];
  endfunction

  // num * 2^FB / den, truncated toward zero and clamped to 32 bits
  function automatic logic [31:0] clamp_quot(longint num, longint den, inout bit ovf);
    longint q;
    q = (num * (longint'(1) <<< FB)) / den;
    if (q > longint'(QMAX)) begin
      ovf = 1'b1;
      q = longint'(QMAX);
    end
    if (q < longint'(QMIN)) begin
      ovf = 1'b1;
      q = longint'(QMIN);
    end
    return q[31:0];
  endfunction

  // expected roots for one coefficient set
  function automatic root_item_t solve_roots(coef_item_t c);
    root_item_t  r;
    longint      a, b, k, s;
    logic [66:0] ma, mb, mc, prod, bsq, four_ac, dmag;
    bit          ac_neg, ovf;
    int          dsign;
    a = longint'(c.coef_a);
    b = longint'(c.coef_b);
    k = longint'(c.coef_c);
    ma = 67'((a < 0) ? -a : a);
    mb = 67'((b < 0) ? -b : b);
    mc = 67'((k < 0) ? -k : k);
    prod = ma * mc;
    bsq = mb * mb;
    four_ac = prod << 2;
    ac_neg = ((a < 0) != (k < 0)) && (prod != 0);
    ovf = 1'b0;
    if (ac_neg) begin
      dmag = bsq + four_ac;
      dsign = (dmag == 0) ? 0 : 1;
    end else if (bsq >= four_ac) begin
      dmag = bsq - four_ac;
      dsign = (bsq == four_ac) ? 0 : 1;
    end else begin
      dmag = four_ac - bsq;
      dsign = -1;
    end
    r = '0;
    r.root_kind = (dsign == 0) ? KIND_ONE : (dsign > 0 ? KIND_TWO : KIND_CPLX);
    r.zero_leading = (a == 0);
    if (a != 0) begin
      s = longint'(floor_sqrt(dmag));
      if (dsign == 0) begin
        r.first_value = clamp_quot(-b, 2 * a, ovf);
      end else if (dsign > 0) begin
        r.first_value = clamp_quot(-b - s, 2 * a, ovf);
        r.second_value = clamp_quot(-b + s, 2 * a, ovf);
      end else begin
        r.first_value = clamp_quot(-b, 2 * a, ovf);
        r.second_value = clamp_quot(s, 2 * a, ovf);
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  // receiver: random gaps per item, optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      root_ready <= 1'b0;
      rx_gap <= 0;
    end else if (rx_hold > 0) begin
      root_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_gap > 0) begin
      root_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (root_ready && root_valid) begin
      if (rx_fast || $urandom_range(0, 2) == 0) begin
        root_ready <= 1'b1;
      end else begin
        root_ready <= 1'b0;
        rx_gap <= $urandom_range(0, 8);
      end
    end else begin
      root_ready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    root_item_t want;
    if (!rst && root_valid && root_ready) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d first=%0d second=%0d",
                   root.root_kind, root.first_value, root.second_value);
      end else begin
        want = pending_roots.pop_front();
        if (root.root_kind !== want.root_kind || root.first_value !== want.first_value ||
            root.second_value !== want.second_value || root.overflow !== want.overflow ||
            root.zero_leading !== want.zero_leading) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind=%0d first=%0d second=%0d ovf=%0b zl=%0b",
                     want.root_kind, want.first_value, want.second_value,
                     want.overflow, want.zero_leading);
            $display("          actual   kind=%0d first=%0d second=%0d ovf=%0b zl=%0b",
                     root.root_kind, root.first_value, root.second_value,
                     root.overflow, root.zero_leading);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one item and wait for it to be taken
  task automatic send_coefs(logic signed [31:0] a, logic signed [31:0] b,
                            logic signed [31:0] c);
    coef_item_t item;
    int gap;
    item.coef_a = a;
    item.coef_b = b;
    item.coef_c = c;
    gap = tx_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      coef_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef <= item;
    coef_valid <= 1'b1;
    do @(posedge clk); while (!coef_ready);
    pending_roots.push_back(solve_roots(item));
  endtask

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return QMIN;
      1: return QMAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // one random coefficient set, mostly shaped to reach each root class
  task automatic send_random_coefs();
    logic signed [31:0] a, b, c;
    int k, m, n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
        c = $urandom;
      end
      3, 4, 5: begin
        a = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
        b = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
        c = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
      end
      6, 7: begin
        // perfect square: b*b equals 4ac exactly
        k = $urandom_range(1, 255);
        m = $urandom_range(1, 255);
        n = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) k = -k;
        a = k * m * m;
        c = k * n * n;
        b = 2 * k * m * n;
        if ($urandom_range(0, 1)) b = -b;
      end
      8: begin
        a = 0;
        b = $urandom_range(0, 3) == 0 ? 0 : $urandom;
        c = $urandom;
      end
      default: begin
        a = pick_edge();
        b = pick_edge();
        c = pick_edge();
      end
    endcase
    send_coefs(a, b, c);
  endtask

  // field extremes and each root class
  task automatic test_directed();
    send_coefs(0, 0, 0);
    send_coefs(0, 5 << FB, 3 << FB);
    send_coefs(0, QMIN, QMAX);
    send_coefs(1 << FB, -(3 << FB), 2 << FB);
    send_coefs(1 << FB, 2 << FB, 1 << FB);
    send_coefs(1, 2, 1);
    send_coefs(1 << FB, 0, 1 << FB);
    send_coefs(-(1 << FB), 0, -(4 << FB));
    send_coefs(-(2 << FB), 3 << FB, 5 << FB);
    send_coefs(QMIN, QMIN, QMIN);
    send_coefs(QMAX, QMAX, QMAX);
    send_coefs(QMIN, QMAX, QMIN);
    send_coefs(QMAX, QMIN, QMAX);
    send_coefs(1, QMAX, 0);
    send_coefs(1, QMIN, 0);
    send_coefs(1, 0, QMIN);
    send_coefs(-1, QMIN, QMAX);
    send_coefs(QMIN, 0, 0);
    send_coefs(QMAX, 0, QMIN);
    send_coefs(-1, -1, -1);
    send_coefs(1, 0, -1);
    send_coefs(QMIN, 1, QMAX);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
      end
      send_random_coefs();
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // receiver stalls long enough for the pipeline to fill and push back
  task automatic test_backpressure();
    tx_fast = 1'b1;
    rx_hold = 300;
    for (int i = 0; i < 120; i++) send_random_coefs();
    tx_fast = 1'b0;
  endtask

  // back-to-back items in both directions
  task automatic test_streaming();
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    for (int i = 0; i < 60; i++) send_random_coefs();
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    coef_valid = 1'b0;
    coef = '0;
    mismatches = 0;
    cycles = 0;
    rx_hold = 0;
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(550);
    test_backpressure();
    test_streaming();
    coef_valid <= 1'b0;

    // drain
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* quadratic_root_solver.f */
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
